FILE: src/mt64_pkg.sv
package mt64_pkg;

  localparam int unsigned NWORDS = 312;
  localparam int unsigned OFFSET = 156;
  localparam int unsigned IDX_W  = 9;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [63:0]      word_t;

  localparam idx_t LAST_IDX   = idx_t'(NWORDS - 1);
  localparam idx_t OFFSET_IDX = idx_t'(OFFSET);

  localparam word_t SEED_DEFAULT = 64'd5489;
  localparam word_t SEED_MULT    = 64'd6364136223846793005;
  localparam word_t UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
  localparam word_t LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
  localparam word_t TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam word_t TEMPER_B     = 64'h5555_5555_5555_5555;
  localparam word_t TEMPER_C     = 64'h71D6_7FFF_EDA6_0000;
  localparam word_t TEMPER_D     = 64'hFFF7_EEE0_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED0,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SWR,
    S_RD1,
    S_RD2,
    S_TWIST
  } state_e;

  typedef struct packed {
    logic seed_init;
    logic mul_en;
    logic mul_a_hi;
    logic mul_b_hi;
    logic acc_init;
    logic acc_add;
    logic seed_write;
    logic rd_pair;
    logic rd_far;
    logic capture_x;
    logic twist;
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

FILE: src/mt64_if.sv
interface mt64_req_if;
  logic valid;
  logic ready;
  logic draw_request;

  modport source (output valid, output draw_request, input ready);
  modport sink (input valid, input draw_request, output ready);
endinterface

interface mt64_rsp_if;
  logic        valid;
  logic        ready;
  logic [62:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

FILE: src/mt64_ctrl.sv
module mt64_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              draw_request_i,
  input  mt64_pkg::status_t status_i,
  output logic              in_ready_o,
  output mt64_pkg::cmd_t    cmd_o
);

  mt64_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mt64_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mt64_pkg::S_IDLE: begin
        if (in_valid_i && draw_request_i) begin
          state_d = status_i.seeded ? mt64_pkg::S_RD1 : mt64_pkg::S_SEED0;
        end
      end
      mt64_pkg::S_SEED0: state_d = mt64_pkg::S_MUL0;
      mt64_pkg::S_MUL0:  state_d = mt64_pkg::S_MUL1;
      mt64_pkg::S_MUL1:  state_d = mt64_pkg::S_MUL2;
      mt64_pkg::S_MUL2:  state_d = mt64_pkg::S_MUL3;
      mt64_pkg::S_MUL3:  state_d = mt64_pkg::S_SWR;
      mt64_pkg::S_SWR: begin
        state_d = status_i.idx_last ? mt64_pkg::S_RD1 : mt64_pkg::S_MUL0;
      end
      mt64_pkg::S_RD1:   state_d = mt64_pkg::S_RD2;
      mt64_pkg::S_RD2:   state_d = mt64_pkg::S_TWIST;
      mt64_pkg::S_TWIST: begin
        if (status_i.out_free) begin
          state_d = mt64_pkg::S_IDLE;
        end
      end
      default: state_d = mt64_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mt64_pkg::S_IDLE:  in_ready_o = 1'b1;
      mt64_pkg::S_SEED0: cmd_o.seed_init = 1'b1;
      mt64_pkg::S_MUL0:  cmd_o.mul_en = 1'b1;
      mt64_pkg::S_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_a_hi = 1'b1;
        cmd_o.acc_init = 1'b1;
      end
      mt64_pkg::S_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_b_hi = 1'b1;
        cmd_o.acc_add  = 1'b1;
      end
      mt64_pkg::S_MUL3:  cmd_o.acc_add = 1'b1;
      mt64_pkg::S_SWR:   cmd_o.seed_write = 1'b1;
      mt64_pkg::S_RD1:   cmd_o.rd_pair = 1'b1;
      mt64_pkg::S_RD2: begin
        cmd_o.rd_far    = 1'b1;
        cmd_o.capture_x = 1'b1;
      end
      mt64_pkg::S_TWIST: cmd_o.twist = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: src/mt64_dp.sv
module mt64_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_wdata_i,
  input  mt64_pkg::cmd_t    cmd_i,
  output mt64_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [62:0]       random_value_o
);

  function automatic mt64_pkg::word_t temper(input mt64_pkg::word_t w);
    mt64_pkg::word_t y;
    y = w;
    y = y ^ ((y >> 29) & mt64_pkg::TEMPER_B);
    y = y ^ ((y << 17) & mt64_pkg::TEMPER_C);
    y = y ^ ((y << 37) & mt64_pkg::TEMPER_D);
    y = y ^ (y >> 43);
    return y;
  endfunction

  mt64_pkg::word_t mem [mt64_pkg::NWORDS];

  mt64_pkg::word_t seed_q;
  mt64_pkg::idx_t  idx_q;
  logic            seeded_q;
  logic            out_valid_q;
  mt64_pkg::word_t p_q, prod_q, acc_q, x_q, rda_q, rdb_q;
  logic [62:0]     out_q;

  mt64_pkg::word_t mix, mul_p, acc_sum, twisted, tempered, wdata;
  logic [31:0]     mul_a, mul_b;
  mt64_pkg::idx_t  nxt_idx, far_idx, raddr;
  logic            idx_last, out_free, mem_we;

  assign idx_last = (idx_q == mt64_pkg::LAST_IDX);
  assign nxt_idx  = idx_last ? '0 : idx_q + 1'b1;
  assign far_idx  = (idx_q >= mt64_pkg::OFFSET_IDX) ? idx_q - mt64_pkg::OFFSET_IDX
                                                    : idx_q + mt64_pkg::OFFSET_IDX;
  assign raddr    = cmd_i.rd_pair ? idx_q : far_idx;

  assign mix      = p_q ^ (p_q >> 62);
  assign mul_a    = cmd_i.mul_a_hi ? mix[63:32] : mix[31:0];
  assign mul_b    = cmd_i.mul_b_hi ? mt64_pkg::SEED_MULT[63:32] : mt64_pkg::SEED_MULT[31:0];
  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign acc_sum  = acc_q + {prod_q[31:0], 32'd0};

  assign twisted  = rda_q ^ (x_q >> 1) ^ (x_q[0] ? mt64_pkg::TWIST_MATRIX : '0);
  assign tempered = temper(twisted);

  assign out_free = !out_valid_q || out_ready_i;

  assign mem_we = cmd_i.seed_init || cmd_i.seed_write || cmd_i.twist;

  always_comb begin
    wdata = twisted;
    if (cmd_i.seed_init) begin
      wdata = seed_q;
    end else if (cmd_i.seed_write) begin
      wdata = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= wdata;
    end
    if (cmd_i.rd_pair || cmd_i.rd_far) begin
      rda_q <= mem[raddr];
    end
    if (cmd_i.rd_pair) begin
      rdb_q <= mem[nxt_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_init) begin
      p_q <= seed_q;
    end else if (cmd_i.seed_write) begin
      p_q <= acc_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.acc_init) begin
      acc_q <= prod_q + {{(64 - mt64_pkg::IDX_W){1'b0}}, idx_q};
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_sum;
    end
    if (cmd_i.capture_x) begin
      x_q <= (rda_q & mt64_pkg::UPPER_MASK) | (rdb_q & mt64_pkg::LOWER_MASK);
    end
    if (cmd_i.twist) begin
      out_q <= tempered[63:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= mt64_pkg::SEED_DEFAULT;
      idx_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.seed_init) begin
        idx_q <= mt64_pkg::idx_t'(1);
      end else if (cmd_i.seed_write || cmd_i.twist) begin
        idx_q <= nxt_idx;
      end
      if (cmd_i.seed_write && idx_last) begin
        seeded_q <= 1'b1;
      end
      if (cmd_i.twist) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.seeded   = seeded_q;
  assign status_o.idx_last = idx_last;
  assign status_o.out_free = out_free;

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_q;

endmodule

FILE: src/mersenne_twister_64_int63_top.sv
// Channel   Dir  Handshake                  Payload
// req_i     in   valid/ready                draw_request (1 bit)
// rsp_o     out  valid/ready                random_value (63 bits)
// cfg       in   cfg_we_i, no wait          cfg_wdata_i -> seed (64 bits)
//
// Once seeded, an item goes through accept, read word pair, read far word, twist and
// temper, in that order; the two-read-port state memory and the controller sequence set these steps.
// The first draw after reset first fills the 312 words from the seed: word 0 from the seed,
// then each further word through four multiply states and a write, on one shared 32x32 multiplier.
// An item with draw_request low is taken while idle and yields nothing.
// rst_ni is asynchronous; seed resets to 5489, the state memory is not cleared.
// A result waits in the output register while the next item is accepted; its twist
// holds until that register is free.
module mersenne_twister_64_int63_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  mt64_req_if.sink    req_i,
  mt64_rsp_if.source  rsp_o
);

  mt64_pkg::cmd_t    cmd;
  mt64_pkg::status_t status;

  mt64_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .draw_request_i (req_i.draw_request),
    .status_i       (status),
    .in_ready_o     (req_i.ready),
    .cmd_o          (cmd)
  );

  mt64_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .random_value_o (rsp_o.random_value)
  );

endmodule
